// ----- hdl/assert_macros.svh -----
// Assertion macros used by the port-level checker of the timer bank.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PTB_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("ptb assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PTB_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("ptb assertion failed");

`endif

// ----- hdl/ptb_pkg.sv -----
// Shared types and constants of the periodic timer bank.
`timescale 1ns / 1ps
package ptb_pkg;

  localparam int CMD_W    = 2;
  localparam int HANDLE_W = 16;
  localparam int TICK_W   = 16;
  localparam int SLOT_W   = 3;
  localparam int KIND_W   = 3;
  localparam int FCNT_W   = 4;

  // Most fired results one tick may produce.
  localparam logic [FCNT_W-1:0] MAX_FIRE = 4'd8;

  localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REG  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SET  = 2'd2;

  localparam logic [KIND_W-1:0] KIND_NONE  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FIRED = 3'd1;
  localparam logic [KIND_W-1:0] KIND_REG   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_FULL  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_SET   = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WALK = 2'b10
  } ptb_state_t;

  // One timer entry as held in the timer memory.
  typedef struct packed {
    logic [TICK_W-1:0] deadline;
    logic [TICK_W-1:0] reload;
  } ptb_timer_t;

endpackage

// ----- hdl/ptb_in_if.sv -----
// Request channel of the timer bank.
`timescale 1ns / 1ps
interface ptb_in_if;
  import ptb_pkg::*;

  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    cmd;
  logic [HANDLE_W-1:0] event_handle;
  logic [SLOT_W-1:0]   timer_index;
  logic [TICK_W-1:0]   period;
  logic                repeat_req;

  modport source (output valid, cmd, event_handle, timer_index, period, repeat_req,
                  input ready);
  modport sink (input valid, cmd, event_handle, timer_index, period, repeat_req,
                output ready);
endinterface

// ----- hdl/ptb_out_if.sv -----
// Result channel of the timer bank.
`timescale 1ns / 1ps
interface ptb_out_if;
  import ptb_pkg::*;

  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [SLOT_W-1:0]   slot;
  logic [HANDLE_W-1:0] fired_handle;
  logic [TICK_W-1:0]   now_tick;
  logic                last;

  modport source (output valid, kind, slot, fired_handle, now_tick, last,
                  input ready);
  modport sink (input valid, kind, slot, fired_handle, now_tick, last,
                output ready);
endinterface

// ----- hdl/periodic_timer_bank.sv -----
// Top level of the periodic timer bank: command decode, slot walk and result register.
//
//   channel   direction  handshake          payload
//   in_chan   in         valid/ready        cmd, event_handle, timer_index, period, repeat_req
//   out_chan  out        valid/ready        kind, slot, fired_handle, now_tick, last
//
// A register or set request is answered from the output register in the cycle after it is accepted.
// A tick request walks the slots through the single memory read port, one slot per cycle
// while the result side does not stall.
// Allocation and armed flags are flip-flops cleared by reset; the memories need no clearing pass.
// A stall on the result side holds the walk on the slot it has just read.
`timescale 1ns / 1ps
module periodic_timer_bank #(
  parameter int NUM_SLOTS = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  ptb_in_if.sink       in_chan,
  ptb_out_if.source    out_chan
);
  import ptb_pkg::*;

  localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CW = $clog2(NUM_SLOTS + 1);

  ptb_state_t           state_r, state_nxt;
  logic [TICK_W-1:0]    tick_r, tick_nxt;
  logic [NUM_SLOTS-1:0] alloc_r, alloc_nxt;
  logic [NUM_SLOTS-1:0] active_r, active_nxt;
  logic [CW-1:0]        rd_cnt_r, rd_cnt_nxt;
  logic                 s2_v_r, s2_v_nxt;
  logic [IW-1:0]        s2_idx_r, s2_idx_nxt;
  logic [FCNT_W-1:0]    fire_cnt_r, fire_cnt_nxt;
  logic                 pend_v_r, pend_v_nxt;
  logic [SLOT_W-1:0]    pend_slot_r, pend_slot_nxt;
  logic [HANDLE_W-1:0]  pend_handle_r, pend_handle_nxt;

  logic                 out_v_r, out_v_nxt;
  logic [KIND_W-1:0]    out_kind_r, out_kind_nxt;
  logic [SLOT_W-1:0]    out_slot_r, out_slot_nxt;
  logic [HANDLE_W-1:0]  out_handle_r, out_handle_nxt;
  logic [TICK_W-1:0]    out_tick_r, out_tick_nxt;
  logic                 out_last_r, out_last_nxt;

  logic                 out_free;
  logic                 in_acc;
  logic                 free_found;
  logic [IW-1:0]        free_idx;
  logic                 set_ok;
  logic                 s2_fire;
  logic                 s2_adv;
  logic                 rd_issue;
  logic                 walk_done;

  logic                 mem_h_we;
  logic                 mem_t_we;
  logic [IW-1:0]        mem_wr_addr;
  ptb_timer_t           mem_t_wdata;
  logic [HANDLE_W-1:0]  rd_handle;
  ptb_timer_t           rd_timer;

  ptb_slot_mem #(
    .DEPTH (NUM_SLOTS),
    .AW    (IW)
  ) u_mem (
    .clk       (clk),
    .rd_en     (rd_issue),
    .rd_addr   (rd_cnt_r[IW-1:0]),
    .wr_addr   (mem_wr_addr),
    .h_we      (mem_h_we),
    .h_wdata   (in_chan.event_handle),
    .t_we      (mem_t_we),
    .t_wdata   (mem_t_wdata),
    .rd_handle (rd_handle),
    .rd_timer  (rd_timer)
  );

  assign out_free       = !out_v_r || out_chan.ready;
  assign in_chan.ready  = (state_r == ST_IDLE) && out_free;
  assign in_acc         = in_chan.valid && in_chan.ready;
  assign set_ok         = {29'd0, in_chan.timer_index} < 32'(NUM_SLOTS);

  // Lowest-numbered slot not yet bound to a handle.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (!alloc_r[i] && !free_found) begin
        free_found = 1'b1;
        free_idx   = IW'(i);
      end
    end
  end

  // Second walk stage: the entry read by the first stage is compared with the new count.
  assign s2_fire   = active_r[s2_idx_r] && (rd_timer.deadline == tick_r) &&
                     (fire_cnt_r < MAX_FIRE);
  assign s2_adv    = s2_v_r && (!s2_fire || !pend_v_r || out_free);
  assign rd_issue  = (state_r == ST_WALK) && (rd_cnt_r < CW'(NUM_SLOTS)) &&
                     (!s2_v_r || s2_adv);
  assign walk_done = (state_r == ST_WALK) && (rd_cnt_r == CW'(NUM_SLOTS)) &&
                     !s2_v_r && out_free;

  always_comb begin
    mem_h_we    = 1'b0;
    mem_t_we    = 1'b0;
    mem_wr_addr = s2_idx_r;
    mem_t_wdata = rd_timer;
    if (state_r == ST_IDLE) begin
      if (in_chan.cmd == CMD_REG) begin
        mem_wr_addr = free_idx;
        mem_h_we    = in_acc && free_found;
      end else begin
        mem_wr_addr          = IW'(in_chan.timer_index);
        mem_t_we             = in_acc && (in_chan.cmd == CMD_SET) && set_ok;
        mem_t_wdata.deadline = tick_r + in_chan.period;
        mem_t_wdata.reload   = in_chan.repeat_req ? in_chan.period : '0;
      end
    end else begin
      // A periodic slot that fires moves its deadline on by its reload.
      mem_t_we             = s2_adv && s2_fire && (rd_timer.reload != '0);
      mem_t_wdata.deadline = tick_r + rd_timer.reload;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    tick_nxt        = tick_r;
    alloc_nxt       = alloc_r;
    active_nxt      = active_r;
    rd_cnt_nxt      = rd_cnt_r;
    s2_v_nxt        = s2_v_r;
    s2_idx_nxt      = s2_idx_r;
    fire_cnt_nxt    = fire_cnt_r;
    pend_v_nxt      = pend_v_r;
    pend_slot_nxt   = pend_slot_r;
    pend_handle_nxt = pend_handle_r;
    out_v_nxt       = out_v_r && !out_chan.ready;
    out_kind_nxt    = out_kind_r;
    out_slot_nxt    = out_slot_r;
    out_handle_nxt  = out_handle_r;
    out_tick_nxt    = out_tick_r;
    out_last_nxt    = out_last_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          out_tick_nxt = tick_r;
          out_last_nxt = 1'b1;
          out_slot_nxt = '0;
          out_handle_nxt = '0;
          out_kind_nxt = KIND_NONE;
          priority if (in_chan.cmd == CMD_TICK) begin
            tick_nxt     = tick_r + 1'b1;
            state_nxt    = ST_WALK;
            rd_cnt_nxt   = '0;
            s2_v_nxt     = 1'b0;
            fire_cnt_nxt = '0;
            pend_v_nxt   = 1'b0;
          end else if (in_chan.cmd == CMD_REG) begin
            out_v_nxt = 1'b1;
            if (free_found) begin
              alloc_nxt[free_idx] = 1'b1;
              out_kind_nxt        = KIND_REG;
              out_slot_nxt        = SLOT_W'(free_idx);
              out_handle_nxt      = in_chan.event_handle;
            end else begin
              out_kind_nxt = KIND_FULL;
            end
          end else if (in_chan.cmd == CMD_SET) begin
            out_v_nxt    = 1'b1;
            out_kind_nxt = KIND_SET;
            out_slot_nxt = in_chan.timer_index;
            if (set_ok) begin
              active_nxt[IW'(in_chan.timer_index)] = 1'b1;
            end
          end else begin
            out_v_nxt = 1'b1;
          end
        end
      end
      ST_WALK: begin
        if (rd_issue) begin
          rd_cnt_nxt = rd_cnt_r + 1'b1;
          s2_v_nxt   = 1'b1;
          s2_idx_nxt = rd_cnt_r[IW-1:0];
        end else if (s2_adv) begin
          s2_v_nxt = 1'b0;
        end
        if (s2_adv && s2_fire) begin
          fire_cnt_nxt = fire_cnt_r + 1'b1;
          if (rd_timer.reload == '0) begin
            active_nxt[s2_idx_r] = 1'b0;
          end
          // The previous fired slot is now known not to be the last result.
          if (pend_v_r) begin
            out_v_nxt      = 1'b1;
            out_kind_nxt   = KIND_FIRED;
            out_slot_nxt   = pend_slot_r;
            out_handle_nxt = pend_handle_r;
            out_tick_nxt   = tick_r;
            out_last_nxt   = 1'b0;
          end
          pend_v_nxt      = 1'b1;
          pend_slot_nxt   = SLOT_W'(s2_idx_r);
          pend_handle_nxt = rd_handle;
        end
        if (walk_done) begin
          state_nxt    = ST_IDLE;
          pend_v_nxt   = 1'b0;
          out_v_nxt    = 1'b1;
          out_tick_nxt = tick_r;
          out_last_nxt = 1'b1;
          if (pend_v_r) begin
            out_kind_nxt   = KIND_FIRED;
            out_slot_nxt   = pend_slot_r;
            out_handle_nxt = pend_handle_r;
          end else begin
            out_kind_nxt   = KIND_NONE;
            out_slot_nxt   = '0;
            out_handle_nxt = '0;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      tick_r     <= '0;
      alloc_r    <= '0;
      active_r   <= '0;
      rd_cnt_r   <= '0;
      s2_v_r     <= 1'b0;
      fire_cnt_r <= '0;
      pend_v_r   <= 1'b0;
      out_v_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      tick_r     <= tick_nxt;
      alloc_r    <= alloc_nxt;
      active_r   <= active_nxt;
      rd_cnt_r   <= rd_cnt_nxt;
      s2_v_r     <= s2_v_nxt;
      fire_cnt_r <= fire_cnt_nxt;
      pend_v_r   <= pend_v_nxt;
      out_v_r    <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s2_idx_r      <= s2_idx_nxt;
    pend_slot_r   <= pend_slot_nxt;
    pend_handle_r <= pend_handle_nxt;
    out_kind_r    <= out_kind_nxt;
    out_slot_r    <= out_slot_nxt;
    out_handle_r  <= out_handle_nxt;
    out_tick_r    <= out_tick_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_chan.valid        = out_v_r;
  assign out_chan.kind         = out_kind_r;
  assign out_chan.slot         = out_slot_r;
  assign out_chan.fired_handle = out_handle_r;
  assign out_chan.now_tick     = out_tick_r;
  assign out_chan.last         = out_last_r;

endmodule

// ----- hdl/ptb_slot_mem.sv -----
// Handle and timer memories of the bank, one read and one write port each.
`timescale 1ns / 1ps
module ptb_slot_mem #(
  parameter int DEPTH = 8,
  parameter int AW    = 3
) (
  input  logic                          clk,
  input  logic                          rd_en,
  input  logic [AW-1:0]                 rd_addr,
  input  logic [AW-1:0]                 wr_addr,
  input  logic                          h_we,
  input  logic [ptb_pkg::HANDLE_W-1:0]  h_wdata,
  input  logic                          t_we,
  input  ptb_pkg::ptb_timer_t           t_wdata,
  output logic [ptb_pkg::HANDLE_W-1:0]  rd_handle,
  output ptb_pkg::ptb_timer_t           rd_timer
);
  import ptb_pkg::*;

  logic [HANDLE_W-1:0] handle_mem [DEPTH];
  ptb_timer_t          timer_mem  [DEPTH];

  always_ff @(posedge clk) begin
    if (h_we) begin
      handle_mem[wr_addr] <= h_wdata;
    end
    if (t_we) begin
      timer_mem[wr_addr] <= t_wdata;
    end
  end

  // Read data is held while no read is issued, so a stalled walk keeps its entry.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_handle <= handle_mem[rd_addr];
      rd_timer  <= timer_mem[rd_addr];
    end
  end

endmodule

// ----- hdl/ptb_checker.sv -----
// Port-level checks of the timer bank and their binding to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ptb_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [ptb_pkg::CMD_W-1:0]     in_cmd,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [ptb_pkg::KIND_W-1:0]    out_kind,
  input logic [ptb_pkg::SLOT_W-1:0]    out_slot,
  input logic [ptb_pkg::HANDLE_W-1:0]  out_handle,
  input logic [ptb_pkg::TICK_W-1:0]    out_tick,
  input logic                          out_last
);
  import ptb_pkg::*;

  // A result that is offered but not taken must stay valid and keep its value.
  `PTB_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_kind) && $stable(out_slot) && $stable(out_handle) && $stable(out_tick) && $stable(out_last))

  // Only fired results can be followed by more results of the same request.
  `PTB_ASSERT_IMP(a_single_last, clk, rst_n, out_valid && (out_kind != KIND_FIRED), out_last)

  // A request other than a tick has its only result ready in the next cycle.
  `PTB_ASSERT_NXT(a_cmd_result, clk, rst_n, in_valid && in_ready && (in_cmd != CMD_TICK), out_valid && out_last)

  // A tick occupies the block while it walks the slots.
  `PTB_ASSERT_NXT(a_tick_busy, clk, rst_n, in_valid && in_ready && (in_cmd == CMD_TICK), !in_ready)

endmodule

bind periodic_timer_bank ptb_checker u_ptb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_chan.valid),
  .in_ready   (in_chan.ready),
  .in_cmd     (in_chan.cmd),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .out_kind   (out_chan.kind),
  .out_slot   (out_chan.slot),
  .out_handle (out_chan.fired_handle),
  .out_tick   (out_chan.now_tick),
  .out_last   (out_chan.last)
);

// ----- verif/periodic_timer_bank_chk.sv -----
// Checker of the timer bank: predicts the results of every request and compares them.
`timescale 1ns / 1ps
module periodic_timer_bank_chk #(
  parameter int NUM_SLOTS = 8
) (
  input  logic clk,
  input  logic rst_n,
  ptb_in_if    in_mon,
  ptb_out_if   out_mon,
  output int   fail_count,
  output int   outstanding
);
  import ptb_pkg::*;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [SLOT_W-1:0]   slot;
    logic [HANDLE_W-1:0] handle;
    logic [TICK_W-1:0]   now;
    logic                last;
  } timer_result_t;

  timer_result_t        pending_results[$];
  logic [TICK_W-1:0]    tick_now;
  logic [NUM_SLOTS-1:0] bound;
  logic [NUM_SLOTS-1:0] armed;
  logic [HANDLE_W-1:0]  handle_of [NUM_SLOTS];
  logic [TICK_W-1:0]    due_at    [NUM_SLOTS];
  logic [TICK_W-1:0]    reload_by [NUM_SLOTS];

  function automatic string show(timer_result_t r);
    return $sformatf("kind %0d slot %0d handle %04h tick %0d last %0b",
                     r.kind, r.slot, r.handle, r.now, r.last);
  endfunction

  task automatic report_mismatch(input string what);
    fail_count++;
    $display("%0t: timer bank mismatch: %s", $time, what);
  endtask

  // Works out the results of one request and moves the timer state on.
  task automatic advance_timers(input logic [CMD_W-1:0]    cmd,
                                input logic [HANDLE_W-1:0] hnd,
                                input logic [SLOT_W-1:0]   idx,
                                input logic [TICK_W-1:0]   per,
                                input logic                rep);
    timer_result_t burst [NUM_SLOTS];
    int n;
    int free_slot;
    n = 0;
    free_slot = -1;
    case (cmd)
      CMD_TICK: begin
        tick_now = tick_now + 1'b1;
        for (int s = 0; s < NUM_SLOTS; s++) begin
          if (n < int'(MAX_FIRE) && armed[s] && due_at[s] == tick_now) begin
            // A zero reload means one-shot, even when the request asked to repeat.
            if (reload_by[s] == '0) armed[s] = 1'b0;
            else due_at[s] = tick_now + reload_by[s];
            burst[n] = '{KIND_FIRED, SLOT_W'(s), handle_of[s], tick_now, 1'b0};
            n++;
          end
        end
      end
      CMD_REG: begin
        for (int s = NUM_SLOTS - 1; s >= 0; s--) begin
          if (!bound[s]) free_slot = s;
        end
        if (free_slot >= 0) begin
          bound[free_slot] = 1'b1;
          handle_of[free_slot] = hnd;
          burst[0] = '{KIND_REG, SLOT_W'(free_slot), hnd, tick_now, 1'b0};
        end else begin
          burst[0] = '{KIND_FULL, '0, '0, tick_now, 1'b0};
        end
        n = 1;
      end
      CMD_SET: begin
        if (int'(idx) < NUM_SLOTS) begin
          reload_by[idx] = rep ? per : '0;
          due_at[idx]    = tick_now + per;
          armed[idx]     = 1'b1;
        end
        burst[0] = '{KIND_SET, idx, '0, tick_now, 1'b0};
        n = 1;
      end
      default: ;
    endcase
    // A tick that fires nothing, and the spare command, give a single empty result.
    if (n == 0) begin
      burst[0] = '{KIND_NONE, '0, '0, tick_now, 1'b0};
      n = 1;
    end
    burst[n-1].last = 1'b1;
    for (int k = 0; k < n; k++) pending_results.push_back(burst[k]);
  endtask

  always @(posedge clk) begin : watch
    timer_result_t want;
    timer_result_t got;
    if (!rst_n) begin
      tick_now   = '0;
      bound      = '0;
      armed      = '0;
      fail_count = 0;
      pending_results.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.kind, out_mon.slot, out_mon.fired_handle, out_mon.now_tick,
                out_mon.last};
        if (pending_results.size() == 0) begin
          report_mismatch({"result with none outstanding: ", show(got)});
        end else begin
          want = pending_results.pop_front();
          if (got.kind !== want.kind || got.slot !== want.slot ||
              got.handle !== want.handle || got.now !== want.now ||
              got.last !== want.last)
            report_mismatch({"got ", show(got), ", wanted ", show(want)});
        end
      end
      if (in_mon.valid && in_mon.ready)
        advance_timers(in_mon.cmd, in_mon.event_handle, in_mon.timer_index,
                       in_mon.period, in_mon.repeat_req);
    end
    outstanding <= pending_results.size();
  end

endmodule

// ----- verif/periodic_timer_bank_tb.sv -----
// Top of the timer bank testbench: clock, reset, request and result sides, verdict.
`timescale 1ns / 1ps
module periodic_timer_bank_tb;
  import ptb_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int BANK_SLOTS   = 8;
  localparam int RANDOM_REQS  = 160;
  // Requests never idle here and results are always taken before the hold-off inside.
  localparam int CALM_FROM    = 60;
  localparam int CALM_TO      = 130;
  localparam int HOLD_AT      = 110;
  localparam int HOLD_CYCLES  = 150;
  // The longest quiet spell of a correct run comes from the hold-off, so this
  // leaves a wide margin.
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 30;
  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  int   sent_total   = 0;
  int   bound_slots  = 0;
  int   quiet_cycles = 0;
  int   fail_count;
  int   outstanding;

  ptb_in_if  in_chan();
  ptb_out_if out_chan();

  periodic_timer_bank #(.NUM_SLOTS(BANK_SLOTS)) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  periodic_timer_bank_chk #(.NUM_SLOTS(BANK_SLOTS)) u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_chan),
    .out_mon     (out_chan),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Offers one request, waits for the edge that accepts it and may idle. Fields that
  // the command does not use are filled at random.
  task automatic send_request(input logic [CMD_W-1:0]    cmd,
                              input logic [HANDLE_W-1:0] hnd,
                              input logic [SLOT_W-1:0]   idx,
                              input logic [TICK_W-1:0]   per,
                              input logic                rep,
                              input bit                  final_req);
    bit calm;
    calm = (sent_total >= CALM_FROM && sent_total < CALM_TO);
    if (cmd != CMD_REG) hnd = HANDLE_W'($urandom);
    if (cmd != CMD_SET) begin
      idx = SLOT_W'($urandom);
      per = TICK_W'($urandom);
      rep = 1'($urandom);
    end
    in_chan.valid        <= 1'b1;
    in_chan.cmd          <= cmd;
    in_chan.event_handle <= hnd;
    in_chan.timer_index  <= idx;
    in_chan.period       <= per;
    in_chan.repeat_req   <= rep;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    sent_total <= sent_total + 1;
    if (cmd == CMD_REG && bound_slots < BANK_SLOTS) bound_slots++;
    if (final_req) begin
      in_chan.valid <= 1'b0;
    end else if (!calm && $urandom_range(0, 99) < 17) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  initial begin : request_side
    int pick;
    logic [CMD_W-1:0]    cmd;
    logic [HANDLE_W-1:0] hnd;
    logic [SLOT_W-1:0]   idx;
    logic [TICK_W-1:0]   per;
    logic                rep;
    in_chan.valid        = 1'b0;
    in_chan.cmd          = CMD_TICK;
    in_chan.event_handle = '0;
    in_chan.timer_index  = '0;
    in_chan.period       = '0;
    in_chan.repeat_req   = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Empty tick and the spare command before anything is bound.
    send_request(CMD_TICK,  '0, '0, '0, 1'b0, 1'b0);
    send_request(CMD_SPARE, '0, '0, '0, 1'b0, 1'b0);
    send_request(CMD_REG, 16'h0000, '0, '0, 1'b0, 1'b0);
    send_request(CMD_REG, 16'hFFFF, '0, '0, 1'b0, 1'b0);
    send_request(CMD_REG, 16'h5AA5, '0, '0, 1'b0, 1'b0);
    send_request(CMD_REG, 16'hA55A, '0, '0, 1'b0, 1'b0);
    // One-shot, periodic, periodic with a zero period, and a deadline that wraps.
    send_request(CMD_SET, '0, 3'd0, 16'd1,     1'b0, 1'b0);
    send_request(CMD_SET, '0, 3'd1, 16'd2,     1'b1, 1'b0);
    send_request(CMD_SET, '0, 3'd2, 16'd0,     1'b1, 1'b0);
    send_request(CMD_SET, '0, 3'd3, 16'hFFFF,  1'b0, 1'b0);
    send_request(CMD_TICK, '0, '0, '0, 1'b0, 1'b0);
    send_request(CMD_TICK, '0, '0, '0, 1'b0, 1'b0);
    // Re-arming an armed slot so that it fires on the same tick as the periodic one.
    send_request(CMD_SET, '0, 3'd3, 16'd2, 1'b0, 1'b0);
    repeat (4) send_request(CMD_TICK, '0, '0, '0, 1'b0, 1'b0);
    send_request(CMD_REG, 16'h1234, '0, '0, 1'b0, 1'b0);
    send_request(CMD_REG, 16'h8001, '0, '0, 1'b0, 1'b0);
    send_request(CMD_REG, 16'h7FFE, '0, '0, 1'b0, 1'b0);
    send_request(CMD_REG, 16'hC3C3, '0, '0, 1'b0, 1'b0);
    // The bank is now full.
    send_request(CMD_REG, 16'h0F0F, '0, '0, 1'b0, 1'b0);
    send_request(CMD_SET, '0, 3'd7, 16'hFFFF, 1'b1, 1'b0);

    for (int k = 0; k < RANDOM_REQS; k++) begin
      pick = $urandom_range(0, 99);
      hnd  = HANDLE_W'($urandom);
      idx  = SLOT_W'($urandom);
      per  = TICK_W'($urandom);
      rep  = 1'($urandom);
      if (pick < 52) begin
        cmd = CMD_TICK;
      end else if (pick < 84 && bound_slots > 0) begin
        // Only bound slots are armed; short periods keep the timers firing.
        cmd = CMD_SET;
        idx = SLOT_W'($urandom_range(0, bound_slots - 1));
        if ($urandom_range(0, 9) != 0) per = TICK_W'($urandom_range(1, 12));
      end else if (pick < 94) begin
        cmd = CMD_REG;
      end else begin
        cmd = CMD_SPARE;
      end
      send_request(cmd, hnd, idx, per, rep, k == RANDOM_REQS - 1);
    end

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin : result_side
    int  hold_left;
    bit  held;
    hold_left = 0;
    held = 1'b0;
    out_chan.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!held && sent_total >= HOLD_AT) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else if (sent_total >= CALM_FROM && sent_total < HOLD_AT) begin
        out_chan.ready <= 1'b1;
      end else begin
        out_chan.ready <= ($urandom_range(0, 99) >= 17);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

// ----- periodic_timer_bank.f -----
+incdir+hdl
hdl/ptb_pkg.sv
hdl/ptb_in_if.sv
hdl/ptb_out_if.sv
hdl/ptb_slot_mem.sv
hdl/periodic_timer_bank.sv
hdl/ptb_checker.sv
verif/periodic_timer_bank_chk.sv
verif/periodic_timer_bank_tb.sv
